### sv/srarq_pkg.sv
// Shared types and constants for the selective-repeat ARQ window block.
// No dependencies; imported by srarq_ctrl, selective_repeat_arq_window, arq_event_checker and the testbench.
package srarq_pkg;

  // Field widths
  localparam int SEQ_W        = 6;
  localparam int CODE_W       = 3;
  localparam int SEQ_BITS_W   = 3;
  localparam int MASK_W       = 32;
  localparam int IN_TDATA_W   = 3 * MASK_W;
  localparam int OUT_TDATA_W  = 16;

  // Defaults
  localparam int WINDOW_MAX_DEF = 32;
  localparam logic [SEQ_BITS_W-1:0] SEQ_BITS_RESET = 3'd3;
  localparam logic [SEQ_BITS_W-1:0] SEQ_BITS_MIN   = 3'd2;
  localparam logic [SEQ_BITS_W-1:0] SEQ_BITS_MAX   = 3'd6;

  // Request kinds carried on tuser
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_ROUND = 1'b1;

  // Event codes
  localparam logic [CODE_W-1:0] EV_RECV_ACK  = 3'd0;
  localparam logic [CODE_W-1:0] EV_RECV_LOST = 3'd1;
  localparam logic [CODE_W-1:0] EV_DUP_ACK   = 3'd2;
  localparam logic [CODE_W-1:0] EV_DUP_LOST  = 3'd3;
  localparam logic [CODE_W-1:0] EV_DAMAGED   = 3'd4;
  localparam logic [CODE_W-1:0] EV_LOST      = 3'd5;

  // One result item
  typedef struct packed {
    logic              last;
    logic [CODE_W-1:0] code;
    logic [SEQ_W-1:0]  seq;
  } event_t;

endpackage

### sv/selective_repeat_arq_window.sv
// Top level of the selective-repeat ARQ window block: configuration register,
// output register, sequencer and two window RAMs. Depends on srarq_pkg, srarq_ram, srarq_ctrl.
//
//  channel   dir  payload                                          transfer when
//  s_*       in   tuser: req_type; tdata: frame_ok, ack_ok, lost  s_tvalid & s_tready
//  m_*       out  tdata: seq_number, event_code; tlast: last_event m_tvalid & m_tready
//  cfg_*     in   cfg_wdata: seq_bits                              cfg_we
//
// A start writes the window slots one after another.
// A round skips each acknowledged slot, searches up to w receiver slots for each open slot
// whose frame arrived, then shifts the kept slots down and refills the freed tail slots.
// The receiver search through the one read port of the window RAM sets the length of a round.
// Reset clears the session; a round before any start emits nothing.
// A stalled output holds only the event in the output register and the one queued behind it.
module selective_repeat_arq_window #(
  parameter int WINDOW_MAX = srarq_pkg::WINDOW_MAX_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [srarq_pkg::IN_TDATA_W-1:0]     s_tdata,   // frame_ok_mask, ack_ok_mask, lost_mask
  input  logic                                 s_tuser,   // req_type
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [srarq_pkg::OUT_TDATA_W-1:0]    m_tdata,   // seq_number, event_code, zero pad
  output logic                                 m_tlast,   // last_event
  input  logic                                 cfg_we,
  input  logic [srarq_pkg::SEQ_BITS_W-1:0]     cfg_wdata  // seq_bits
);

  import srarq_pkg::*;

  localparam int AW = $clog2(WINDOW_MAX);

  logic [SEQ_BITS_W-1:0] seq_bits;
  logic                  ev_valid;
  logic                  ev_ready;
  event_t                ev;
  event_t                out_ev;

  logic                  tx_we;
  logic [AW-1:0]         tx_waddr;
  logic [SEQ_W-1:0]      tx_wdata;
  logic [AW-1:0]         tx_raddr;
  logic [SEQ_W-1:0]      tx_rdata;
  logic                  rx_we;
  logic [AW-1:0]         rx_waddr;
  logic [SEQ_W-1:0]      rx_wdata;
  logic [AW-1:0]         rx_raddr;
  logic [SEQ_W-1:0]      rx_rdata;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_bits <= SEQ_BITS_RESET;
    end else if (cfg_we) begin
      seq_bits <= cfg_wdata;
    end
  end

  // Output register: take a new event when empty or draining
  assign ev_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ev_valid && ev_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid && ev_ready) begin
      out_ev <= ev;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - CODE_W - SEQ_W)'(0), out_ev.code, out_ev.seq};
  assign m_tlast = out_ev.last;

  srarq_ctrl #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .seq_bits      (seq_bits),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .req_type      (s_tuser),
    .frame_ok_mask (s_tdata[MASK_W-1:0]),
    .ack_ok_mask   (s_tdata[2*MASK_W-1:MASK_W]),
    .lost_mask     (s_tdata[3*MASK_W-1:2*MASK_W]),
    .ev_valid      (ev_valid),
    .ev_ready      (ev_ready),
    .ev            (ev),
    .tx_we         (tx_we),
    .tx_waddr      (tx_waddr),
    .tx_wdata      (tx_wdata),
    .tx_raddr      (tx_raddr),
    .tx_rdata      (tx_rdata),
    .rx_we         (rx_we),
    .rx_waddr      (rx_waddr),
    .rx_wdata      (rx_wdata),
    .rx_raddr      (rx_raddr),
    .rx_rdata      (rx_rdata)
  );

  // Sender window sequence numbers
  srarq_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (WINDOW_MAX)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  // Receiver window sequence numbers
  srarq_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (WINDOW_MAX)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (rx_wdata),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

endmodule

### sv/srarq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srarq_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/srarq_ctrl.sv
// Sequencer for the ARQ windows: session start, slot walk with receiver search,
// and sender window compaction. Depends on srarq_pkg; drives two srarq_ram instances.
module srarq_ctrl #(
  parameter int WINDOW_MAX = srarq_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [srarq_pkg::SEQ_BITS_W-1:0]    seq_bits,
  // request side
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic [srarq_pkg::MASK_W-1:0]        frame_ok_mask,
  input  logic [srarq_pkg::MASK_W-1:0]        ack_ok_mask,
  input  logic [srarq_pkg::MASK_W-1:0]        lost_mask,
  // event side
  output logic                                ev_valid,
  input  logic                                ev_ready,
  output srarq_pkg::event_t                   ev,
  // sender window RAM
  output logic                                tx_we,
  output logic [$clog2(WINDOW_MAX)-1:0]       tx_waddr,
  output logic [srarq_pkg::SEQ_W-1:0]         tx_wdata,
  output logic [$clog2(WINDOW_MAX)-1:0]       tx_raddr,
  input  logic [srarq_pkg::SEQ_W-1:0]         tx_rdata,
  // receiver window RAM
  output logic                                rx_we,
  output logic [$clog2(WINDOW_MAX)-1:0]       rx_waddr,
  output logic [srarq_pkg::SEQ_W-1:0]         rx_wdata,
  output logic [$clog2(WINDOW_MAX)-1:0]       rx_raddr,
  input  logic [srarq_pkg::SEQ_W-1:0]         rx_rdata
);

  import srarq_pkg::*;

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int CW = $clog2(WINDOW_MAX + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_INIT  = 4'd1;
  localparam logic [3:0] ST_WALK  = 4'd2;
  localparam logic [3:0] ST_TXRD  = 4'd3;
  localparam logic [3:0] ST_RXRD  = 4'd4;
  localparam logic [3:0] ST_RXCMP = 4'd5;
  localparam logic [3:0] ST_EMIT  = 4'd6;
  localparam logic [3:0] ST_CPRD  = 4'd7;
  localparam logic [3:0] ST_CPWR  = 4'd8;
  localparam logic [3:0] ST_FILL  = 4'd9;

  logic [3:0]            state;
  logic                  session;
  logic [CW-1:0]         wuse;
  logic [SEQ_W-1:0]      mmask;
  logic [SEQ_W-1:0]      snext;
  logic [SEQ_W-1:0]      rnext;
  logic [WINDOW_MAX-1:0] acked;
  logic [WINDOW_MAX-1:0] fok;
  logic [WINDOW_MAX-1:0] aok;
  logic [WINDOW_MAX-1:0] lost;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         sidx;
  logic [CW-1:0]         lead_cnt;
  logic                  lead_run;
  logic [SEQ_W-1:0]      seq_r;

  // Window size and sequence mask for a new session
  logic [SEQ_BITS_W-1:0] bits_c;
  logic [SEQ_W:0]        half_c;
  logic [SEQ_W:0]        space_c;
  logic [CW-1:0]         w_start;

  always_comb begin
    priority if (seq_bits < SEQ_BITS_MIN) begin
      bits_c = SEQ_BITS_MIN;
    end else if (seq_bits > SEQ_BITS_MAX) begin
      bits_c = SEQ_BITS_MAX;
    end else begin
      bits_c = seq_bits;
    end
    half_c  = (SEQ_W + 1)'(1) << (bits_c - SEQ_BITS_W'(1));
    space_c = half_c << 1;
    if (half_c > (SEQ_W + 1)'(WINDOW_MAX)) begin
      w_start = CW'(WINDOW_MAX);
    end else begin
      w_start = CW'(half_c);
    end
  end

  // Window masks: slots below wuse, slots kept after compaction, slots at or below idx
  logic [WINDOW_MAX:0]   wmask_x;
  logic [WINDOW_MAX:0]   tail_x;
  logic [WINDOW_MAX:0]   low_x;
  logic [WINDOW_MAX-1:0] wmask;
  logic [WINDOW_MAX-1:0] unacked_above;
  logic [WINDOW_MAX-1:0] acked_shift;
  logic                  last_c;
  logic                  match;
  logic [AW-1:0]         slot;

  assign slot          = idx[AW-1:0];
  assign wmask_x       = ((WINDOW_MAX + 1)'(1) << wuse) - (WINDOW_MAX + 1)'(1);
  assign tail_x        = ((WINDOW_MAX + 1)'(1) << (wuse - lead_cnt)) - (WINDOW_MAX + 1)'(1);
  assign low_x         = ((WINDOW_MAX + 1)'(2) << slot) - (WINDOW_MAX + 1)'(1);
  assign wmask         = wmask_x[WINDOW_MAX-1:0];
  assign unacked_above = ~acked & wmask & ~low_x[WINDOW_MAX-1:0];
  assign last_c        = ~|unacked_above;
  assign acked_shift   = ((acked >> lead_cnt) & tail_x[WINDOW_MAX-1:0]) | (acked & ~wmask);
  assign match         = (rx_rdata == seq_r);

  assign in_ready = (state == ST_IDLE);
  assign ev_valid = (state == ST_EMIT);

  // RAM port control
  always_comb begin
    tx_raddr = slot;
    rx_raddr = sidx[AW-1:0];
    tx_we    = (state == ST_INIT) || (state == ST_CPWR) ||
               ((state == ST_FILL) && (sidx != wuse));
    rx_we    = (state == ST_INIT) || ((state == ST_RXCMP) && match);
    tx_waddr = sidx[AW-1:0];
    rx_waddr = sidx[AW-1:0];
    tx_wdata = snext;
    rx_wdata = rnext;
    unique case (state)
      ST_INIT: begin
        tx_waddr = slot;
        rx_waddr = slot;
        tx_wdata = SEQ_W'(idx);
        rx_wdata = SEQ_W'(idx);
      end
      ST_CPWR: begin
        tx_wdata = tx_rdata;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      session  <= 1'b0;
      wuse     <= '0;
      mmask    <= '0;
      snext    <= '0;
      rnext    <= '0;
      acked    <= '0;
      idx      <= '0;
      sidx     <= '0;
      lead_cnt <= '0;
      lead_run <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            fok  <= frame_ok_mask[WINDOW_MAX-1:0];
            aok  <= ack_ok_mask[WINDOW_MAX-1:0];
            lost <= lost_mask[WINDOW_MAX-1:0];
            idx  <= '0;
            if (req_type == REQ_START) begin
              wuse    <= w_start;
              mmask   <= SEQ_W'(space_c - (SEQ_W + 1)'(1));
              snext   <= SEQ_W'(w_start);
              rnext   <= SEQ_W'(w_start);
              session <= 1'b1;
              state   <= ST_INIT;
            end else if (session) begin
              lead_cnt <= '0;
              lead_run <= 1'b1;
              state    <= ST_WALK;
            end
          end
        end
        // load both windows with 0..w-1
        ST_INIT: begin
          acked[slot] <= 1'b0;
          idx         <= idx + CW'(1);
          if (idx == wuse - CW'(1)) begin
            state <= ST_IDLE;
          end
        end
        // take the next slot, skip acknowledged ones
        ST_WALK: begin
          if (idx == wuse) begin
            if (lead_cnt == '0) begin
              state <= ST_IDLE;
            end else begin
              acked <= acked_shift;
              idx   <= lead_cnt;
              sidx  <= '0;
              state <= ST_CPRD;
            end
          end else if (acked[slot]) begin
            if (lead_run) begin
              lead_cnt <= lead_cnt + CW'(1);
            end
            idx <= idx + CW'(1);
          end else begin
            state <= ST_TXRD;
          end
        end
        ST_TXRD: begin
          seq_r <= tx_rdata;
          if (fok[slot]) begin
            sidx  <= '0;
            state <= ST_RXRD;
          end else begin
            ev.seq  <= tx_rdata;
            ev.code <= lost[slot] ? EV_LOST : EV_DAMAGED;
            ev.last <= last_c;
            state   <= ST_EMIT;
          end
        end
        ST_RXRD: begin
          state <= ST_RXCMP;
        end
        // compare one receiver slot; advance it on a hit
        ST_RXCMP: begin
          if (match || (sidx == wuse - CW'(1))) begin
            if (match) begin
              rnext <= (rnext + SEQ_W'(1)) & mmask;
            end
            if (aok[slot]) begin
              acked[slot] <= 1'b1;
              ev.code     <= match ? EV_RECV_ACK : EV_DUP_ACK;
            end else begin
              ev.code     <= match ? EV_RECV_LOST : EV_DUP_LOST;
            end
            ev.seq  <= seq_r;
            ev.last <= last_c;
            state   <= ST_EMIT;
          end else begin
            sidx  <= sidx + CW'(1);
            state <= ST_RXRD;
          end
        end
        // hold the event until the output stage takes it
        ST_EMIT: begin
          if (ev_ready) begin
            if (lead_run && acked[slot]) begin
              lead_cnt <= lead_cnt + CW'(1);
            end else begin
              lead_run <= 1'b0;
            end
            idx   <= idx + CW'(1);
            state <= ST_WALK;
          end
        end
        // shift remaining sender slots down
        ST_CPRD: begin
          if (idx == wuse) begin
            state <= ST_FILL;
          end else begin
            state <= ST_CPWR;
          end
        end
        ST_CPWR: begin
          idx   <= idx + CW'(1);
          sidx  <= sidx + CW'(1);
          state <= ST_CPRD;
        end
        // refill the tail with fresh sequence numbers
        ST_FILL: begin
          if (sidx == wuse) begin
            state <= ST_IDLE;
          end else begin
            snext <= (snext + SEQ_W'(1)) & mmask;
            sidx  <= sidx + CW'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // No event while a request can be taken
  a_idle_no_event: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !ev_valid)
    else $error("event offered while idle");

  // A stalled event holds its payload
  a_event_hold: assert property (@(posedge clk) disable iff (rst)
    (ev_valid && !ev_ready) |=> (ev_valid && $stable(ev)))
    else $error("event changed under stall");

  // Rounds run only inside a session
  a_no_round_before_start: assert property (@(posedge clk) disable iff (rst)
    !session |-> (state == ST_IDLE || state == ST_INIT))
    else $error("round running before any start");

  // Window size stays within range once a session exists
  a_window_range: assert property (@(posedge clk) disable iff (rst)
    session |-> (wuse >= CW'(2) && wuse <= CW'(WINDOW_MAX)))
    else $error("window size out of range");

endmodule

### test/arq_event_checker.sv
// Event checker for the selective-repeat ARQ window block: mirrors both windows,
// predicts the events of every round and compares them with the output stream.
// Depends on srarq_pkg.
`timescale 1ns / 100ps

module arq_event_checker #(
  parameter int WINDOW_MAX = srarq_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [srarq_pkg::IN_TDATA_W-1:0]  s_tdata,   // frame_ok_mask, ack_ok_mask, lost_mask
  input  logic                              s_tuser,   // req_type
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [srarq_pkg::OUT_TDATA_W-1:0] m_tdata,   // seq_number, event_code, zero pad
  input  logic                              m_tlast,   // last_event
  input  logic                              cfg_we,
  input  logic [srarq_pkg::SEQ_BITS_W-1:0]  cfg_wdata, // seq_bits
  output int                                fail_count,
  output int                                pending_events,
  output int                                checked_events
);

  import srarq_pkg::*;

  // Mirrored window state
  logic [SEQ_W-1:0]      tx_seq   [MASK_W];
  logic                  tx_acked [MASK_W];
  logic [SEQ_W-1:0]      rx_seq   [MASK_W];
  logic [SEQ_W-1:0]      tx_next;
  logic [SEQ_W-1:0]      rx_next;
  int                    win_size;
  bit                    session_open;
  logic [SEQ_BITS_W-1:0] seq_bits_reg;
  int                    live_bits;

  event_t                expected_events[$];
  int                    errors;
  int                    seen;

  // Out-of-range register values act as the nearest legal one
  function automatic int clamp_seq_bits(logic [SEQ_BITS_W-1:0] b);
    if (b < SEQ_BITS_MIN) return SEQ_BITS_MIN;
    if (b > SEQ_BITS_MAX) return SEQ_BITS_MAX;
    return b;
  endfunction

  // Load both windows with 0..w-1 and latch the sequence width
  task automatic open_session();
    int space;
    live_bits = clamp_seq_bits(seq_bits_reg);
    space     = 1 << live_bits;
    win_size  = space / 2;
    if (win_size > WINDOW_MAX) win_size = WINDOW_MAX;
    if (win_size > MASK_W) win_size = MASK_W;
    for (int i = 0; i < win_size; i++) begin
      tx_seq[i]   = SEQ_W'(i);
      rx_seq[i]   = SEQ_W'(i);
      tx_acked[i] = 1'b0;
    end
    tx_next      = SEQ_W'(win_size & (space - 1));
    rx_next      = SEQ_W'(win_size & (space - 1));
    session_open = 1'b1;
  endtask

  // Walk the open slots, queue one event each, then compact the sender window
  task automatic run_round(logic [MASK_W-1:0] fok, logic [MASK_W-1:0] aok,
                           logic [MASK_W-1:0] lost);
    logic [SEQ_W-1:0] seq_mask;
    event_t           ev;
    bit               found;
    int               produced;
    int               lead;
    int               keep;
    if (!session_open) return;
    seq_mask = SEQ_W'((1 << live_bits) - 1);
    produced = 0;
    for (int i = 0; i < win_size; i++) begin
      if (!tx_acked[i]) begin
        ev.seq  = tx_seq[i];
        ev.last = 1'b0;
        if (fok[i]) begin
          // advance the matching receiver slot, if any
          found = 1'b0;
          for (int j = 0; j < win_size && !found; j++) begin
            if (rx_seq[j] == ev.seq) begin
              rx_seq[j] = rx_next;
              rx_next   = (rx_next + 1'b1) & seq_mask;
              found     = 1'b1;
            end
          end
          if (aok[i]) begin
            tx_acked[i] = 1'b1;
            ev.code     = found ? EV_RECV_ACK : EV_DUP_ACK;
          end else begin
            ev.code = found ? EV_RECV_LOST : EV_DUP_LOST;
          end
        end else begin
          ev.code = lost[i] ? EV_LOST : EV_DAMAGED;
        end
        expected_events.push_back(ev);
        produced++;
      end
    end
    if (produced > 0) expected_events[expected_events.size()-1].last = 1'b1;

    // drop leading acknowledged slots, shift the rest down, refill the tail
    lead = 0;
    while (lead < win_size && tx_acked[lead]) lead++;
    keep = win_size - lead;
    for (int k = 0; k < keep; k++) begin
      tx_seq[k]   = tx_seq[k + lead];
      tx_acked[k] = tx_acked[k + lead];
    end
    for (int k = keep; k < win_size; k++) begin
      tx_seq[k]   = tx_next;
      tx_next     = (tx_next + 1'b1) & seq_mask;
      tx_acked[k] = 1'b0;
    end
  endtask

  initial begin
    errors         = 0;
    seen           = 0;
    fail_count     = 0;
    pending_events = 0;
    checked_events = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      seq_bits_reg = SEQ_BITS_RESET;
      live_bits    = SEQ_BITS_MIN;
      win_size     = 0;
      session_open = 1'b0;
      tx_next      = '0;
      rx_next      = '0;
      for (int i = 0; i < MASK_W; i++) begin
        tx_seq[i]   = '0;
        rx_seq[i]   = '0;
        tx_acked[i] = 1'b0;
      end
      expected_events.delete();
    end else begin
      // compare an output transfer with the oldest expected event
      if (m_tvalid && m_tready) begin
        seen++;
        if (expected_events.size() == 0) begin
          $error("unexpected event: seq_number %0d event_code %0d last_event %0b",
                 m_tdata[SEQ_W-1:0], m_tdata[SEQ_W +: CODE_W], m_tlast);
          errors++;
        end else begin
          event_t want;
          want = expected_events.pop_front();
          if (m_tdata[SEQ_W-1:0] !== want.seq) begin
            $error("seq_number mismatch: expected %0d, got %0d",
                   want.seq, m_tdata[SEQ_W-1:0]);
            errors++;
          end
          if (m_tdata[SEQ_W +: CODE_W] !== want.code) begin
            $error("event_code mismatch: expected %0d, got %0d",
                   want.code, m_tdata[SEQ_W +: CODE_W]);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last_event mismatch: expected %0b, got %0b", want.last, m_tlast);
            errors++;
          end
        end
      end

      // predict on every input transfer
      if (s_tvalid && s_tready) begin
        if (s_tuser == REQ_START) open_session();
        else run_round(s_tdata[MASK_W-1:0], s_tdata[2*MASK_W-1:MASK_W],
                       s_tdata[3*MASK_W-1:2*MASK_W]);
      end

      if (cfg_we) seq_bits_reg = cfg_wdata;
    end

    // publish after the edge so readers never race the update
    fail_count     <= errors;
    pending_events <= expected_events.size();
    checked_events <= seen;
  end

endmodule

### test/tb_selective_repeat_arq_window.sv
// Testbench top for selective_repeat_arq_window: drives requests, configuration
// and output back-pressure, and reports the verdict from arq_event_checker.
// Depends on srarq_pkg, selective_repeat_arq_window and arq_event_checker.
`timescale 1ns / 100ps

module tb_selective_repeat_arq_window;
  import srarq_pkg::*;

  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int PHASES        = 10;
  // sequence-bit setting per random phase, phase 0 in the lowest bits
  localparam logic [PHASES*SEQ_BITS_W-1:0] PHASE_PLAN =
    {3'd2, 3'd4, 3'd7, 3'd5, 3'd1, 3'd3, 3'd6, 3'd5, 3'd2, 3'd4};
  localparam logic [MASK_W-1:0] ALL_ONES = '1;
  localparam logic [MASK_W-1:0] NONE     = '0;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tuser   = REQ_START;
  logic                   m_tready  = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [SEQ_BITS_W-1:0]  cfg_wdata = '0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  int fail_count;
  int pending_events;
  int checked_events;
  int requests_sent = 0;
  int cycle_count   = 0;
  int sender_calm   = 0;

  selective_repeat_arq_window dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  arq_event_checker event_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending_events (pending_events),
    .checked_events (checked_events)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Random gap before a transfer, with occasional stretches of no gaps
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = $urandom_range(10, 60);
    return $urandom_range(0, 8);
  endfunction

  // Channel outcome mask with roughly pct percent of bits set
  function automatic logic [MASK_W-1:0] draw_mask(int unsigned pct);
    logic [MASK_W-1:0] v;
    for (int i = 0; i < MASK_W; i++) v[i] = ($urandom_range(0, 99) < pct);
    return v;
  endfunction

  function automatic int unsigned draw_pct();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 100;
      default: return $urandom_range(40, 100);
    endcase
  endfunction

  // Present one request and hold it until the transfer
  task automatic send_request(logic req, logic [MASK_W-1:0] fok, logic [MASK_W-1:0] aok,
                              logic [MASK_W-1:0] lost);
    int gap;
    gap = draw_gap(sender_calm);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {lost, aok, fok};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
  endtask

  // Stop sending, wait for every expected event, then let the block finish up
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_events != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seq_bits(logic [SEQ_BITS_W-1:0] value);
    wait_idle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Output back-pressure
  initial begin
    int gap;
    int calm;
    calm = 0;
    forever begin
      gap = draw_gap(calm);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Watchdog expired after %0d cycles", cycle_count);
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    logic [SEQ_BITS_W-1:0] phase_bits;
    int                    n_rounds;
    logic [MASK_W-1:0]     fok;
    logic [MASK_W-1:0]     aok;
    logic [MASK_W-1:0]     lost;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // round before any start: ignored
    send_request(REQ_ROUND, ALL_ONES, ALL_ONES, ALL_ONES);
    // reset width, four slots; start masks are ignored
    send_request(REQ_START, ALL_ONES, ALL_ONES, ALL_ONES);
    send_request(REQ_ROUND, NONE, NONE, ALL_ONES);       // all lost
    send_request(REQ_ROUND, NONE, ALL_ONES, NONE);       // all damaged
    send_request(REQ_ROUND, ALL_ONES, NONE, NONE);       // received, acks lost
    send_request(REQ_ROUND, ALL_ONES, NONE, ALL_ONES);   // duplicates, acks lost
    send_request(REQ_ROUND, ALL_ONES, ALL_ONES, NONE);   // duplicates acked
    send_request(REQ_ROUND, ALL_ONES, ALL_ONES, NONE);   // fresh frames after wrap
    // mixed outcomes; bits above the window must be ignored
    send_request(REQ_ROUND, 32'hFFFF_FFF5, 32'hFFFF_FFF1, 32'h0000_0002);
    send_request(REQ_ROUND, ALL_ONES, ALL_ONES, NONE);
    send_request(REQ_START, NONE, NONE, NONE);           // restart mid-session
    send_request(REQ_ROUND, ALL_ONES, 32'h0000_000A, NONE);

    // width below range acts as the smallest window
    write_seq_bits(3'd0);
    send_request(REQ_START, NONE, NONE, NONE);
    send_request(REQ_ROUND, ALL_ONES, ALL_ONES, NONE);
    send_request(REQ_ROUND, ALL_ONES, ALL_ONES, NONE);
    send_request(REQ_ROUND, 32'h0000_0001, 32'h0000_0001, ALL_ONES);

    // width above range acts as the largest window
    write_seq_bits(3'd7);
    send_request(REQ_START, NONE, NONE, NONE);
    send_request(REQ_ROUND, ALL_ONES, NONE, NONE);
    send_request(REQ_ROUND, NONE, NONE, ALL_ONES);
    send_request(REQ_ROUND, ALL_ONES, ALL_ONES, NONE);
    send_request(REQ_ROUND, ALL_ONES, 32'h5555_5555, NONE);
    send_request(REQ_ROUND, $urandom, $urandom, $urandom);

    // random phases: one width each, a start, then mostly rounds
    for (int p = 0; p < PHASES; p++) begin
      phase_bits = PHASE_PLAN[p*SEQ_BITS_W +: SEQ_BITS_W];
      write_seq_bits(phase_bits);
      send_request(REQ_START, $urandom, $urandom, $urandom);
      n_rounds = (phase_bits >= SEQ_BITS_MAX) ? 6 : 17;
      for (int r = 0; r < n_rounds; r++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_request(REQ_START, $urandom, $urandom, $urandom);
        end else begin
          if ($urandom_range(0, 9) == 0) begin
            fok  = $urandom;
            aok  = $urandom;
            lost = $urandom;
          end else begin
            fok  = draw_mask(draw_pct());
            aok  = draw_mask(draw_pct());
            lost = draw_mask($urandom_range(0, 100));
          end
          send_request(REQ_ROUND, fok, aok, lost);
        end
      end
    end

    wait_idle();
    $display("Sent %0d requests and checked %0d events", requests_sent, checked_events);
    $display("Widths 0..7 clamped to 2..6, windows of 2 to 32 slots, restarts included");
    if (fail_count == 0 && pending_events == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### selective_repeat_arq_window.f
sv/srarq_pkg.sv
sv/srarq_ram.sv
sv/srarq_ctrl.sv
sv/selective_repeat_arq_window.sv
test/arq_event_checker.sv
test/tb_selective_repeat_arq_window.sv
